>>> sv/json_path_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// JSON path tokenizer assertion macros
// Shared property wrappers, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JSON_PATH_TOKENIZER_MACROS_SVH
`define JSON_PATH_TOKENIZER_MACROS_SVH

// same-cycle implication
`define JPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define JPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/jpt_pkg.sv
// ----------------------------------------------------------------------------
// JSON path tokenizer package
// Word types, token and error codes, parser states and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package jpt_pkg;

   localparam int IDX_W  = 63;
   localparam int QDEPTH = 4;
   localparam int QAW    = $clog2(QDEPTH);

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef enum logic [2:0] {
      KIND_ROOT    = 3'd0,
      KIND_KEYBYTE = 3'd1,
      KIND_KEYEND  = 3'd2,
      KIND_INDEX   = 3'd3,
      KIND_WILD    = 3'd4,
      KIND_ERROR   = 3'd5,
      KIND_DONE    = 3'd6
   } kind_type;

   typedef enum logic [3:0] {
      ERR_EMPTY       = 4'd0,
      ERR_NOROOT      = 4'd1,
      ERR_RECURSIVE   = 4'd2,
      ERR_EMPTYKEY    = 4'd3,
      ERR_BRACKET     = 4'd4,
      ERR_QUOTE       = 4'd5,
      ERR_WILD        = 4'd6,
      ERR_INDEX       = 4'd7,
      ERR_UNSUPPORTED = 4'd8
   } err_type;

   typedef enum logic [3:0] {
      ST_ROOT      = 4'd0,
      ST_MAIN      = 4'd1,
      ST_DOT_FIRST = 4'd2,
      ST_DOT_KEY   = 4'd3,
      ST_BRACKET   = 4'd4,
      ST_QKEY      = 4'd5,
      ST_QCLOSE    = 4'd6,
      ST_STAR      = 4'd7,
      ST_INDEX     = 4'd8,
      ST_SKIP      = 4'd9
   } state_type;

   typedef struct packed {
      logic [7:0] ch;
      logic       end_mark;
   } req_type;

   typedef struct packed {
      kind_type         kind;
      logic [7:0]       key_byte;
      logic [IDX_W-1:0] index_value;
      err_type          error_code;
      logic             last;
   } rsp_type;

   // one queued action: a token, optionally followed by a done token
   typedef struct packed {
      rsp_type rsp;
      logic    add_done;
   } action_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

`default_nettype wire

>>> sv/jpt_front.sv
// ----------------------------------------------------------------------------
// JSON path tokenizer front end
// Accepts path words, runs the parser state machine and index accumulator,
// and pushes token actions into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module jpt_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire jpt_pkg::req_type    req_data,
   input  wire logic                q_full,
   output logic                     push,
   output jpt_pkg::action_type      push_data
);
   import jpt_pkg::*;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] acc_ff, acc_in;
   logic             ovf_ff, ovf_in;
   logic             seen_ff, seen_in;

   logic             accept;
   logic             is_digit;
   logic [3:0]       dval;
   logic [IDX_W+3:0] prod;
   logic             do_fail;
   err_type          fail_code;
   logic             act_valid;
   action_type       act;

   assign accept = req_valid && !q_full;
   assign push   = accept && act_valid;
   assign push_data = act;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ROOT;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         seen_ff  <= seen_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      seen_in   = seen_ff;
      act       = '0;
      act_valid = 1'b0;
      do_fail   = 1'b0;
      fail_code = ERR_EMPTY;
      is_digit  = (req_data.ch >= CH_ZERO) && (req_data.ch <= CH_NINE);
      dval      = 4'(req_data.ch - CH_ZERO);
      // acc * 10 + digit, wide enough to see overflow past 63 bits
      prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + (IDX_W+4)'(dval);

      unique case (state_ff)
         ST_ROOT: begin
            if (req_data.end_mark) begin
               do_fail = 1'b1; fail_code = ERR_EMPTY;
            end else if (req_data.ch != CH_DOLLAR) begin
               do_fail = 1'b1; fail_code = ERR_NOROOT;
            end else begin
               state_in = ST_MAIN;
               act_valid = 1'b1;
               act.rsp.kind = KIND_ROOT;
            end
         end
         ST_MAIN: begin
            if (req_data.end_mark) begin
               state_in = ST_ROOT;
               act_valid = 1'b1;
               act.rsp.kind = KIND_DONE;
               act.rsp.last = 1'b1;
            end else if (req_data.ch == CH_DOT) begin
               state_in = ST_DOT_FIRST;
            end else if (req_data.ch == CH_LBRACK) begin
               state_in = ST_BRACKET;
            end else begin
               do_fail = 1'b1; fail_code = ERR_UNSUPPORTED;
            end
         end
         ST_DOT_FIRST: begin
            if (req_data.end_mark) begin
               do_fail = 1'b1; fail_code = ERR_EMPTYKEY;
            end else if (req_data.ch == CH_DOT) begin
               do_fail = 1'b1; fail_code = ERR_RECURSIVE;
            end else if (req_data.ch == CH_LBRACK) begin
               do_fail = 1'b1; fail_code = ERR_EMPTYKEY;
            end else begin
               state_in = ST_DOT_KEY;
               act_valid = 1'b1;
               act.rsp.kind = KIND_KEYBYTE;
               act.rsp.key_byte = req_data.ch;
            end
         end
         ST_DOT_KEY: begin
            act_valid = 1'b1;
            if (req_data.end_mark) begin
               // key end now, done follows from the back end
               state_in = ST_ROOT;
               act.rsp.kind = KIND_KEYEND;
               act.add_done = 1'b1;
            end else if (req_data.ch == CH_DOT) begin
               state_in = ST_DOT_FIRST;
               act.rsp.kind = KIND_KEYEND;
            end else if (req_data.ch == CH_LBRACK) begin
               state_in = ST_BRACKET;
               act.rsp.kind = KIND_KEYEND;
            end else begin
               act.rsp.kind = KIND_KEYBYTE;
               act.rsp.key_byte = req_data.ch;
            end
         end
         ST_BRACKET: begin
            if (req_data.end_mark) begin
               do_fail = 1'b1; fail_code = ERR_BRACKET;
            end else if (req_data.ch == CH_QUOTE) begin
               state_in = ST_QKEY;
            end else if (req_data.ch == CH_STAR) begin
               state_in = ST_STAR;
            end else if (!is_digit) begin
               do_fail = 1'b1; fail_code = ERR_INDEX;
            end else begin
               acc_in   = IDX_W'(dval);
               ovf_in   = 1'b0;
               seen_in  = 1'b1;
               state_in = ST_INDEX;
            end
         end
         ST_QKEY: begin
            if (req_data.end_mark) begin
               do_fail = 1'b1; fail_code = ERR_QUOTE;
            end else if (req_data.ch == CH_QUOTE) begin
               state_in = ST_QCLOSE;
            end else begin
               act_valid = 1'b1;
               act.rsp.kind = KIND_KEYBYTE;
               act.rsp.key_byte = req_data.ch;
            end
         end
         ST_QCLOSE: begin
            if (req_data.end_mark || req_data.ch != CH_RBRACK) begin
               do_fail = 1'b1; fail_code = ERR_QUOTE;
            end else begin
               state_in = ST_MAIN;
               act_valid = 1'b1;
               act.rsp.kind = KIND_KEYEND;
            end
         end
         ST_STAR: begin
            if (req_data.end_mark || req_data.ch != CH_RBRACK) begin
               do_fail = 1'b1; fail_code = ERR_WILD;
            end else begin
               state_in = ST_MAIN;
               act_valid = 1'b1;
               act.rsp.kind = KIND_WILD;
            end
         end
         ST_INDEX: begin
            if (req_data.end_mark) begin
               do_fail = 1'b1; fail_code = ERR_INDEX;
            end else if (is_digit) begin
               // freeze the accumulator once it overflows
               if (!ovf_ff) begin
                  if (prod[IDX_W+3:IDX_W] != 4'd0) begin
                     ovf_in = 1'b1;
                  end else begin
                     acc_in = prod[IDX_W-1:0];
                  end
               end
               seen_in = 1'b1;
            end else if (req_data.ch != CH_RBRACK || !seen_ff || ovf_ff) begin
               do_fail = 1'b1; fail_code = ERR_INDEX;
            end else begin
               state_in = ST_MAIN;
               act_valid = 1'b1;
               act.rsp.kind = KIND_INDEX;
               act.rsp.index_value = acc_ff;
            end
         end
         ST_SKIP: begin
            if (req_data.end_mark) begin
               state_in = ST_ROOT;
            end
         end
         default: begin
            state_in = ST_ROOT;
         end
      endcase

      if (do_fail) begin
         state_in = req_data.end_mark ? ST_ROOT : ST_SKIP;
         act = '0;
         act_valid = 1'b1;
         act.rsp.kind = KIND_ERROR;
         act.rsp.error_code = fail_code;
         act.rsp.last = 1'b1;
      end
   end

endmodule

`default_nettype wire

>>> sv/jpt_queue.sv
// ----------------------------------------------------------------------------
// JSON path tokenizer action queue
// Small first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module jpt_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire jpt_pkg::action_type  push_data,
   input  wire logic                 pop,
   output jpt_pkg::action_type       head,
   output jpt_pkg::q_status_type     status
);
   import jpt_pkg::*;

   action_type     mem_ff [QDEPTH];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW:0]   count_ff, count_in;

   assign head             = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == (QAW+1)'(QDEPTH));
   assign status.not_empty = (count_ff != '0);

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/jpt_back.sv
// ----------------------------------------------------------------------------
// JSON path tokenizer back end
// Pops queued actions and drives the registered result word, expanding
// a key end at path end into key end then done.
// ----------------------------------------------------------------------------
`default_nettype none

module jpt_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire jpt_pkg::action_type   head,
   input  wire jpt_pkg::q_status_type q_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output jpt_pkg::rsp_type           rsp_data
);
   import jpt_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    pend_ff, pend_in;
   logic    advance;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop       = advance && !pend_ff && q_status.not_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      if (advance) begin
         if (pend_ff) begin
            rsp_valid_in     = 1'b1;
            rsp_data_in      = '0;
            rsp_data_in.kind = KIND_DONE;
            rsp_data_in.last = 1'b1;
            pend_in          = 1'b0;
         end else if (q_status.not_empty) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = head.rsp;
            pend_in      = head.add_done;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

endmodule

`default_nettype wire

>>> sv/json_path_tokenizer.sv
// ----------------------------------------------------------------------------
// JSON path tokenizer
// Tokenizes a path one byte word at a time into root, key, index, wildcard,
// error and done tokens.
//
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_stall  | ch, end_mark
//   rsp     | out       | rsp_valid / rsp_stall  | kind, key_byte, index_value,
//           |           |                        | error_code, last
//
// One request word per cycle while req_stall is low; its result passes through
// the action queue and output register. A key end at path end gives two results.
// The front parser takes words while the four-entry action queue has room.
// Synchronous reset returns the parser to expecting the root and empties
// the queue and output register. A stalled result holds while the front
// keeps taking words until the queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

`include "json_path_tokenizer_macros.svh"

module json_path_tokenizer (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire jpt_pkg::req_type  req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output jpt_pkg::rsp_type       rsp_data
);
   import jpt_pkg::*;

   logic         push;
   action_type   push_data;
   logic         pop;
   action_type   head;
   q_status_type q_status;

   assign req_stall = q_status.full;

   jpt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_status.full),
      .push      (push),
      .push_data (push_data)
   );

   jpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   jpt_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   `JPT_ASSERT_NOW(a_no_push_full, q_status.full, !push, "push into full queue")
   `JPT_ASSERT_NOW(a_no_pop_empty, !q_status.not_empty, !pop, "pop from empty queue")
   `JPT_ASSERT_NOW(a_error_last, rsp_valid && rsp_data.kind == KIND_ERROR, rsp_data.last, "error without last")
   `JPT_ASSERT_NOW(a_last_kind, rsp_valid && rsp_data.last, rsp_data.kind == KIND_DONE || rsp_data.kind == KIND_ERROR, "last on non-final token")
   `JPT_ASSERT_NEXT(a_key_end_done, push && push_data.add_done, q_status.not_empty, "lost key end action")

endmodule

`default_nettype wire

>>> tb/sv/tb_json_path_tokenizer.sv
// ----------------------------------------------------------------------------
// JSON path tokenizer testbench
// Streams directed and random path bytes into the tokenizer with random gaps
// and output stalls, predicts the token stream word by word and compares each
// token field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_json_path_tokenizer;
   timeunit 1ns;
   timeprecision 1ps;

   import jpt_pkg::*;

   localparam int          CYCLE_LIMIT  = 200000;
   localparam int          RANDOM_WORDS = 450;
   localparam int          DRAIN_CYCLES = 20;
   localparam int          LONG_HOLD    = 80;
   localparam int          HOLD_AFTER   = 120;
   localparam logic [63:0] MAX63        = 64'h7FFF_FFFF_FFFF_FFFF;
   // zero code carried by non-error tokens
   localparam err_type     NO_ERR       = ERR_EMPTY;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   req_type req_data  = '0;
   logic    rsp_stall = 1'b0;
   logic    req_stall;
   logic    rsp_valid;
   rsp_type rsp_data;

   json_path_tokenizer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   req_type    pending_words[$];
   rsp_type    expected_tokens[$];
   logic [7:0] path_bytes[$];

   int mismatches     = 0;
   int tokens_checked = 0;
   int cycle_count    = 0;
   int gap_left       = 0;
   int stall_left     = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   bit send_gaps      = 1'b1;
   bit recv_gaps      = 1'b1;

   // tokenizer shadow state
   state_type   path_state = ST_ROOT;
   logic [62:0] idx_acc    = '0;
   logic        idx_ovf    = 1'b0;
   logic        digit_seen = 1'b0;

   function automatic bit winding_down();
      return pending_words.size() < 60;
   endfunction

   // ---------------------------------------------------------------- predictor
   function automatic void push_token(kind_type k, logic [7:0] kb, logic [62:0] idx,
                                      err_type code, logic last);
      rsp_type t;
      t.kind        = k;
      t.key_byte    = kb;
      t.index_value = idx;
      t.error_code  = code;
      t.last        = last;
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic void parse_error(err_type code, logic at_end);
      path_state = at_end ? ST_ROOT : ST_SKIP;
      push_token(KIND_ERROR, 8'd0, '0, code, 1'b1);
   endfunction

   function automatic void tokenize(req_type w);
      logic [7:0]  c;
      logic        fin;
      logic        is_digit;
      logic [63:0] d;
      c        = w.ch;
      fin      = w.end_mark;
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      d        = 64'(c - CH_ZERO);
      case (path_state)
         ST_ROOT: begin
            if (fin) parse_error(ERR_EMPTY, 1'b1);
            else if (c != CH_DOLLAR) parse_error(ERR_NOROOT, 1'b0);
            else begin
               path_state = ST_MAIN;
               push_token(KIND_ROOT, 8'd0, '0, NO_ERR, 1'b0);
            end
         end
         ST_MAIN: begin
            if (fin) begin
               path_state = ST_ROOT;
               push_token(KIND_DONE, 8'd0, '0, NO_ERR, 1'b1);
            end else if (c == CH_DOT) path_state = ST_DOT_FIRST;
            else if (c == CH_LBRACK) path_state = ST_BRACKET;
            else parse_error(ERR_UNSUPPORTED, 1'b0);
         end
         ST_DOT_FIRST: begin
            if (fin) parse_error(ERR_EMPTYKEY, 1'b1);
            else if (c == CH_DOT) parse_error(ERR_RECURSIVE, 1'b0);
            else if (c == CH_LBRACK) parse_error(ERR_EMPTYKEY, 1'b0);
            else begin
               path_state = ST_DOT_KEY;
               push_token(KIND_KEYBYTE, c, '0, NO_ERR, 1'b0);
            end
         end
         ST_DOT_KEY: begin
            if (fin) begin
               push_token(KIND_KEYEND, 8'd0, '0, NO_ERR, 1'b0);
               path_state = ST_ROOT;
               push_token(KIND_DONE, 8'd0, '0, NO_ERR, 1'b1);
            end else if (c == CH_DOT || c == CH_LBRACK) begin
               path_state = (c == CH_DOT) ? ST_DOT_FIRST : ST_BRACKET;
               push_token(KIND_KEYEND, 8'd0, '0, NO_ERR, 1'b0);
            end else begin
               push_token(KIND_KEYBYTE, c, '0, NO_ERR, 1'b0);
            end
         end
         ST_BRACKET: begin
            if (fin) parse_error(ERR_BRACKET, 1'b1);
            else if (c == CH_QUOTE) path_state = ST_QKEY;
            else if (c == CH_STAR) path_state = ST_STAR;
            else if (!is_digit) parse_error(ERR_INDEX, 1'b0);
            else begin
               idx_acc    = d[62:0];
               idx_ovf    = 1'b0;
               digit_seen = 1'b1;
               path_state = ST_INDEX;
            end
         end
         ST_QKEY: begin
            if (fin) parse_error(ERR_QUOTE, 1'b1);
            else if (c == CH_QUOTE) path_state = ST_QCLOSE;
            else push_token(KIND_KEYBYTE, c, '0, NO_ERR, 1'b0);
         end
         ST_QCLOSE: begin
            if (fin) parse_error(ERR_QUOTE, 1'b1);
            else if (c != CH_RBRACK) parse_error(ERR_QUOTE, 1'b0);
            else begin
               path_state = ST_MAIN;
               push_token(KIND_KEYEND, 8'd0, '0, NO_ERR, 1'b0);
            end
         end
         ST_STAR: begin
            if (fin) parse_error(ERR_WILD, 1'b1);
            else if (c != CH_RBRACK) parse_error(ERR_WILD, 1'b0);
            else begin
               path_state = ST_MAIN;
               push_token(KIND_WILD, 8'd0, '0, NO_ERR, 1'b0);
            end
         end
         ST_INDEX: begin
            if (fin) parse_error(ERR_INDEX, 1'b1);
            else if (is_digit) begin
               // freeze: once past 2^63-1 the value is dead
               if (!idx_ovf) begin
                  if ({1'b0, idx_acc} > (MAX63 - d) / 10) idx_ovf = 1'b1;
                  else idx_acc = 63'({1'b0, idx_acc} * 10 + d);
               end
               digit_seen = 1'b1;
            end else if (c != CH_RBRACK || !digit_seen || idx_ovf) begin
               parse_error(ERR_INDEX, 1'b0);
            end else begin
               path_state = ST_MAIN;
               push_token(KIND_INDEX, 8'd0, idx_acc, NO_ERR, 1'b0);
            end
         end
         default: begin
            if (fin) path_state = ST_ROOT;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------ checker
   function automatic void field_diff(string field, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t: token %0d %s expected %0h got %0h",
                  $time, tokens_checked, field, want, got);
      end
   endfunction

   function automatic void check_token(rsp_type got);
      rsp_type want;
      if (expected_tokens.size() == 0) begin
         mismatches++;
         $display("%0t: token with nothing expected, got kind %0d key %0h idx %0h",
                  $time, got.kind, got.key_byte, got.index_value);
         $display("%0t: unexpected token err %0d last %0b",
                  $time, got.error_code, got.last);
         return;
      end
      want = expected_tokens.pop_front();
      field_diff("kind", 64'(want.kind), 64'(got.kind));
      field_diff("key_byte", 64'(want.key_byte), 64'(got.key_byte));
      field_diff("index_value", 64'(want.index_value), 64'(got.index_value));
      field_diff("error_code", 64'(want.error_code), 64'(got.error_code));
      field_diff("last", 64'(want.last), 64'(got.last));
      tokens_checked++;
   endfunction

   // predict first so a same-edge token can never race its own prediction
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) tokenize(req_data);
         if (rsp_valid && !rsp_stall) check_token(rsp_data);
      end
   end

   // ------------------------------------------------------------------- driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if ($urandom_range(0, 49) == 0) send_gaps = !send_gaps;
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!winding_down() && send_gaps && $urandom_range(0, 5) == 0) begin
               gap_left = $urandom_range(1, 16) - 1;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_data  <= pending_words.pop_front();
            end
         end
      end
   end

   // ----------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ($urandom_range(0, 49) == 0) recv_gaps = !recv_gaps;
         // one long hold to back the queue up into the input
         if (!hold_done && tokens_checked >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!winding_down() && recv_gaps && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 16) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d tokens still expected", $time, expected_tokens.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus
   // queue the path bytes followed by the end marker; returns words queued
   function automatic int send_path();
      req_type w;
      int      n;
      n = path_bytes.size() + 1;
      foreach (path_bytes[i]) begin
         w.ch       = path_bytes[i];
         w.end_mark = 1'b0;
         pending_words.insert(pending_words.size(), w);
      end
      w.ch       = 8'($urandom);
      w.end_mark = 1'b1;
      pending_words.insert(pending_words.size(), w);
      path_bytes.delete();
      return n;
   endfunction

   function automatic logic [7:0] key_char(logic [7:0] skip_a, logic [7:0] skip_b);
      logic [7:0] b;
      do b = 8'($urandom); while (b == skip_a || b == skip_b);
      return b;
   endfunction

   function automatic logic [7:0] pick_special();
      case ($urandom_range(0, 7))
         0: return CH_DOT;
         1: return CH_LBRACK;
         2: return CH_RBRACK;
         3: return CH_STAR;
         4: return CH_QUOTE;
         5: return CH_DOLLAR;
         6: return CH_ZERO + 8'($urandom_range(0, 9));
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic void add_byte(logic [7:0] b);
      path_bytes.insert(path_bytes.size(), b);
   endfunction

   function automatic void push_digits(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void push_number(logic [63:0] v);
      logic [7:0] digs[$];
      do begin
         digs.push_front(CH_ZERO + 8'(v % 10));
         v = v / 10;
      end while (v != 0);
      foreach (digs[i]) add_byte(digs[i]);
   endfunction

   function automatic void add_segment();
      int n;
      case ($urandom_range(0, 3))
         0: begin
            add_byte(CH_DOT);
            n = $urandom_range(1, 4);
            repeat (n) add_byte(key_char(CH_DOT, CH_LBRACK));
         end
         1: begin
            add_byte(CH_LBRACK);
            add_byte(CH_QUOTE);
            n = $urandom_range(0, 3);
            repeat (n) add_byte(key_char(CH_QUOTE, CH_QUOTE));
            add_byte(CH_QUOTE);
            add_byte(CH_RBRACK);
         end
         2: begin
            add_byte(CH_LBRACK);
            add_byte(CH_STAR);
            add_byte(CH_RBRACK);
         end
         default: begin
            add_byte(CH_LBRACK);
            case ($urandom_range(0, 11))
               0: push_digits("9223372036854775807");
               1: push_digits("9223372036854775808");
               2: push_digits("18446744073709551616");
               3: begin
                  push_digits("00");
                  push_number(64'($urandom_range(0, 99)));
               end
               4: push_number({$urandom, $urandom} & MAX63);
               default: push_number(64'($urandom_range(0, 999)));
            endcase
            add_byte(CH_RBRACK);
         end
      endcase
   endfunction

   // mostly well-formed paths; some damaged, some pure noise
   function automatic int random_path();
      int sel;
      int n;
      sel = $urandom_range(0, 19);
      if (sel < 2) begin
         n = $urandom_range(1, 5);
         repeat (n) add_byte(($urandom_range(0, 1) == 0) ? pick_special() : 8'($urandom));
      end else begin
         add_byte(CH_DOLLAR);
         n = $urandom_range(0, 4);
         repeat (n) add_segment();
         if (sel < 6) begin
            case ($urandom_range(0, 3))
               0: path_bytes.insert($urandom_range(0, path_bytes.size()), pick_special());
               1: begin
                  n = $urandom_range(0, path_bytes.size() - 1);
                  while (path_bytes.size() > n) void'(path_bytes.pop_back());
               end
               2: path_bytes[$urandom_range(0, path_bytes.size() - 1)] = pick_special();
               default: path_bytes.delete(0);
            endcase
         end
      end
      return send_path();
   endfunction

   initial begin
      int random_count;
      random_count = 0;

      // directed: empty, bad root, double dot, empty key, bracket at end,
      // zero byte in a key, wildcard then stray byte, empty quoted key
      void'(send_path());
      path_bytes = '{8'hFF};
      void'(send_path());
      path_bytes = '{CH_DOLLAR, CH_DOT, CH_DOT};
      void'(send_path());
      path_bytes = '{CH_DOLLAR, CH_DOT};
      void'(send_path());
      path_bytes = '{CH_DOLLAR, CH_LBRACK};
      void'(send_path());
      path_bytes = '{CH_DOLLAR, CH_DOT, 8'h00};
      void'(send_path());
      path_bytes = '{CH_DOLLAR, CH_LBRACK, CH_STAR, CH_RBRACK, 8'h7F};
      void'(send_path());
      path_bytes = '{CH_DOLLAR, CH_LBRACK, CH_QUOTE, CH_QUOTE, CH_RBRACK};
      void'(send_path());

      while (random_count < RANDOM_WORDS) random_count += random_path();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
